>>> design/sapq_pkg.sv
// shared types and constants for the sorted array priority queue
// no dependencies; every other design file refers to it by scoped names
`default_nettype none

package sapq_pkg;

    // request operation codes
    localparam logic [2:0] FUNC_ENQUEUE = 3'd0;
    localparam logic [2:0] FUNC_DEQUEUE = 3'd1;
    localparam logic [2:0] FUNC_SEARCH  = 3'd2;
    localparam logic [2:0] FUNC_UPDATE  = 3'd3;
    localparam logic [2:0] FUNC_CLEAR   = 3'd4;

    // result status codes
    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_FULL     = 2'd1;
    localparam logic [1:0] STAT_EMPTY    = 2'd2;
    localparam logic [1:0] STAT_NOTFOUND = 2'd3;

    // request beat
    typedef struct packed {
        logic        [2:0]  func;
        logic signed [31:0] value;
        logic signed [31:0] new_value;
    } t_req;

    // result beat
    typedef struct packed {
        logic        [1:0]  status;
        logic signed [31:0] data_out;
        logic        [4:0]  position;
        logic        [4:0]  count;
        logic               is_empty;
        logic signed [31:0] head_value;
    } t_rsp;

    // what every cell does in a cycle
    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_REMOVE = 2'd2,
        CELL_SHIFT  = 2'd3
    } t_cell_op;

    // broadcast control to the row of cells
    typedef struct packed {
        t_cell_op           op;
        logic signed [31:0] key;
    } t_cell_ctl;

    // what a cell hands to its right-hand neighbor
    typedef struct packed {
        logic signed [31:0] data;
        logic               gt;
    } t_link;

endpackage

`default_nettype wire

>>> design/sapq_cell.sv
// one compare-and-shift cell of the sorted row
// depends on sapq_pkg for the control and link types
`default_nettype none

module sapq_cell (
    input  wire logic               i_clk,
    input  wire sapq_pkg::t_cell_ctl i_ctl,
    input  wire logic               i_occ,
    input  wire sapq_pkg::t_link    i_left,
    input  wire logic signed [31:0] i_right_data,
    output sapq_pkg::t_link         o_link,
    output logic                    o_ge,
    output logic                    o_eq
);

    logic signed [31:0] r_data;
    logic signed [31:0] n_data;
    logic               w_gt;

    // compares against the broadcast key
    assign w_gt   = i_occ && (r_data > i_ctl.key);
    assign o_ge   = i_occ && (r_data >= i_ctl.key);
    assign o_eq   = i_occ && (r_data == i_ctl.key);
    assign o_link = '{data: r_data, gt: w_gt};

    // next entry: take from the left, from the right, the key, or keep
    always_comb begin
        case (i_ctl.op)
            sapq_pkg::CELL_INSERT: begin
                if (i_left.gt) begin
                    n_data = i_left.data;
                end else if (w_gt || !i_occ) begin
                    n_data = i_ctl.key;
                end else begin
                    n_data = r_data;
                end
            end
            sapq_pkg::CELL_REMOVE: begin
                n_data = o_ge ? i_right_data : r_data;
            end
            sapq_pkg::CELL_SHIFT: begin
                n_data = i_right_data;
            end
            default: begin
                n_data = r_data;
            end
        endcase
    end

    // entry storage, no reset
    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

endmodule

`default_nettype wire

>>> design/sorted_array_priority_queue_core.sv
// top level of the sorted array min-priority queue: control and a row of cells
// depends on sapq_pkg and sapq_cell
//
//   channel   ports                      direction  beat taken when
//   request   start, busy, i_req         in         start && !busy at a rising edge
//   result    o_strobe, o_rsp            out        o_strobe high, one cycle each
//
// every request but an update that finds its old value gives its result in the
// cycle after acceptance; such an update removes, then inserts across the row,
// and holds busy high while it inserts. the row of cells works on every entry
// at once, so the count of entries does not change the timing.
// a synchronous reset empties the queue; entry storage is not cleared.
// the receiver cannot stall, so a result is never held back.
`default_nettype none

module sorted_array_priority_queue_core #(
    parameter int CAPACITY = 16
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire sapq_pkg::t_req i_req,
    output logic               o_strobe,
    output sapq_pkg::t_rsp     o_rsp
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(CAPACITY);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    typedef enum logic [1:0] {
        S_IDLE   = 2'b01,
        S_INSERT = 2'b10
    } t_state;

    t_state             r_state, n_state;
    logic [CW-1:0]      r_count, n_count;
    logic               r_strobe, n_strobe;
    logic [1:0]         r_status, n_status;
    logic signed [31:0] r_data_out, n_data_out;
    logic [4:0]         r_position, n_position;
    logic signed [31:0] r_new_value, n_new_value;

    sapq_pkg::t_cell_ctl w_ctl;
    sapq_pkg::t_link     w_link [CAPACITY];
    logic [CAPACITY-1:0] w_occ, w_ge, w_eq, w_first;
    logic [IW-1:0]       w_idx;
    logic [IW+4:0]       w_pos_sum;
    logic [CW+4:0]       w_count_ext;
    logic                w_found, w_empty, w_full, w_accept;

    // row of cells
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        sapq_pkg::t_link    w_left;
        logic signed [31:0] w_right;

        assign w_occ[g] = (CW'(g) < r_count);

        if (g == 0) begin : g_head
            assign w_left = '{data: '0, gt: 1'b0};
        end else begin : g_mid
            assign w_left = w_link[g-1];
        end

        if (g == CAPACITY - 1) begin : g_tail
            assign w_right = w_link[g].data;
        end else begin : g_body
            assign w_right = w_link[g+1].data;
        end

        sapq_cell u_cell (
            .i_clk       (i_clk),
            .i_ctl       (w_ctl),
            .i_occ       (w_occ[g]),
            .i_left      (w_left),
            .i_right_data(w_right),
            .o_link      (w_link[g]),
            .o_ge        (w_ge[g]),
            .o_eq        (w_eq[g])
        );
    end

    // first match in the row and its index; equal entries sit together
    always_comb begin
        w_idx = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            w_first[i] = w_eq[i] && ((i == 0) ? 1'b1 : !w_eq[(i == 0) ? 0 : i - 1]);
            w_idx      = w_idx | (w_first[i] ? IW'(i) : '0);
        end
    end

    assign w_found   = |w_eq;
    assign w_empty   = (r_count == '0);
    assign w_full    = (r_count >= CAP_C);
    assign w_pos_sum = (IW+5)'(w_idx) + (IW+5)'(1);
    assign busy      = (r_state == S_INSERT);
    assign w_accept  = start && !busy;

    // request decode and cell control
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_strobe    = 1'b0;
        n_status    = sapq_pkg::STAT_OK;
        n_data_out  = '0;
        n_position  = '0;
        n_new_value = r_new_value;
        w_ctl       = '{op: sapq_pkg::CELL_HOLD, key: i_req.value};
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_strobe = 1'b1;
                    case (i_req.func)
                        sapq_pkg::FUNC_ENQUEUE: begin
                            if (w_full) begin
                                n_status = sapq_pkg::STAT_FULL;
                            end else begin
                                w_ctl.op = sapq_pkg::CELL_INSERT;
                                n_count  = r_count + CW'(1);
                            end
                        end
                        sapq_pkg::FUNC_DEQUEUE: begin
                            if (w_empty) begin
                                n_status = sapq_pkg::STAT_EMPTY;
                            end else begin
                                w_ctl.op   = sapq_pkg::CELL_SHIFT;
                                n_data_out = w_link[0].data;
                                n_count    = r_count - CW'(1);
                            end
                        end
                        sapq_pkg::FUNC_SEARCH: begin
                            if (w_empty) begin
                                n_status = sapq_pkg::STAT_EMPTY;
                            end else if (!w_found) begin
                                n_status = sapq_pkg::STAT_NOTFOUND;
                            end else begin
                                n_position = w_pos_sum[4:0];
                            end
                        end
                        sapq_pkg::FUNC_UPDATE: begin
                            if (w_empty) begin
                                n_status = sapq_pkg::STAT_EMPTY;
                            end else if (!w_found) begin
                                n_status = sapq_pkg::STAT_NOTFOUND;
                            end else begin
                                w_ctl.op    = sapq_pkg::CELL_REMOVE;
                                n_count     = r_count - CW'(1);
                                n_new_value = i_req.new_value;
                                n_strobe    = 1'b0;
                                n_state     = S_INSERT;
                            end
                        end
                        sapq_pkg::FUNC_CLEAR: begin
                            n_count = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_INSERT: begin
                // second half of an update: insert the new value
                w_ctl    = '{op: sapq_pkg::CELL_INSERT, key: r_new_value};
                n_count  = r_count + CW'(1);
                n_strobe = 1'b1;
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_strobe <= n_strobe;
        end
    end

    // result and update payload registers
    always_ff @(posedge i_clk) begin
        r_new_value <= n_new_value;
        if (n_strobe) begin
            r_status   <= n_status;
            r_data_out <= n_data_out;
            r_position <= n_position;
        end
    end

    // result beat; count and head come straight from the stored state
    assign w_count_ext = (CW+5)'(r_count);
    assign o_strobe    = r_strobe;
    always_comb begin
        o_rsp.status     = r_status;
        o_rsp.data_out   = r_data_out;
        o_rsp.position   = r_position;
        o_rsp.count      = w_count_ext[4:0];
        o_rsp.is_empty   = w_empty;
        o_rsp.head_value = w_empty ? 32'sd0 : w_link[0].data;
    end

endmodule

`default_nettype wire

>>> design/sapq_checker.sv
// port-level checks for the sorted array priority queue, bound to the top level
// depends on sapq_pkg and sorted_array_priority_queue_core
`default_nettype none

module sapq_checker (
    input wire logic           i_clk,
    input wire logic           i_rst_n,
    input wire logic           start,
    input wire logic           busy,
    input wire sapq_pkg::t_req i_req,
    input wire logic           o_strobe,
    input wire sapq_pkg::t_rsp o_rsp
);

    // the insert half of an update lasts a single cycle
    a_busy_short: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> !busy)
        else $error("busy held for more than one cycle");

    // an accepted beat gives a result next cycle unless an update goes on
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (o_strobe || busy))
        else $error("accepted request gave no result");

    // a finished update brings its result in the cycle that busy drops
    a_update_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> o_strobe)
        else $error("update result missing after insert cycle");

    // a zero count implies the empty flag, and the empty flag a zero head
    a_empty_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> ((o_rsp.is_empty == (o_rsp.count == 5'd0) || o_rsp.count != 5'd0)
                      && (!o_rsp.is_empty || o_rsp.head_value == 32'sd0)))
        else $error("empty flag and head value disagree");

    // a failed request reports a zero removed value and a zero position
    a_data_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_rsp.status != sapq_pkg::STAT_OK) |-> (o_rsp.data_out == 32'sd0
                                                             && o_rsp.position == 5'd0))
        else $error("payload set on a failed request");

endmodule

bind sorted_array_priority_queue_core sapq_checker u_sapq_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .i_req   (i_req),
    .o_strobe(o_strobe),
    .o_rsp   (o_rsp)
);

`default_nettype wire

>>> sim/tb.sv
// self-checking testbench for the sorted array min-priority queue core
// depends on sapq_pkg and sorted_array_priority_queue_core; keeps its own sorted-list model
// to predict each result beat and compares every field of the result
`default_nettype none

module tb;

    localparam int QUEUE_DEPTH    = 16;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int PHASE_COUNT    = 15;
    localparam int PHASE_ITEMS    = 40;
    localparam int POOL_DEPTH     = 32;

    // func codes the block ignores
    localparam logic [2:0] FUNC_SPARE_LO  = 3'd5;
    localparam logic [2:0] FUNC_SPARE_MID = 3'd6;
    localparam logic [2:0] FUNC_SPARE_HI  = 3'd7;

    localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] VAL_MAX = 32'sh7fff_ffff;

    // one request waiting to be driven
    typedef struct {
        sapq_pkg::t_req req;
        bit             drain_before;
    } t_pq_request;

    logic           i_clk   = 1'b0;
    logic           i_rst_n = 1'b0;
    logic           start   = 1'b0;
    sapq_pkg::t_req i_req   = '0;
    logic           busy;
    logic           o_strobe;
    sapq_pkg::t_rsp o_rsp;

    t_pq_request            pending_reqs[$];
    sapq_pkg::t_rsp         expected_rsps[$];
    logic signed [31:0]     value_pool[$];

    // model of the queue contents, ascending
    logic signed [31:0]     model_ent[QUEUE_DEPTH];
    int                     model_fill = 0;

    int n_sent      = 0;
    int n_checked   = 0;
    int n_errors    = 0;
    int idle_cycles = 0;
    int burst_left  = 0;
    int gap_left    = 0;
    bit took;

    sorted_array_priority_queue_core #(
        .CAPACITY(QUEUE_DEPTH)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_req   (i_req),
        .o_strobe(o_strobe),
        .o_rsp   (o_rsp)
    );

    always #4 i_clk = ~i_clk;

    // insert keeping ascending order; caller checks there is room
    function automatic void model_insert(input logic signed [31:0] v);
        int i;
        i = model_fill;
        while (i > 0 && model_ent[i - 1] > v) begin
            model_ent[i] = model_ent[i - 1];
            i--;
        end
        model_ent[i] = v;
        model_fill++;
    endfunction

    function automatic void model_remove(input int pos);
        for (int i = pos + 1; i < model_fill; i++) begin
            model_ent[i - 1] = model_ent[i];
        end
        model_fill--;
    endfunction

    // index of the first equal entry, model_fill when absent
    function automatic int model_find(input logic signed [31:0] key);
        for (int i = 0; i < model_fill; i++) begin
            if (model_ent[i] == key) begin
                return i;
            end
        end
        return model_fill;
    endfunction

    // apply one request to the model and return the result beat it gives
    function automatic sapq_pkg::t_rsp apply_queue_op(input sapq_pkg::t_req r);
        sapq_pkg::t_rsp rsp;
        int             idx;
        rsp = '0;
        rsp.status = sapq_pkg::STAT_OK;
        case (r.func)
            sapq_pkg::FUNC_ENQUEUE: begin
                if (model_fill >= QUEUE_DEPTH) rsp.status = sapq_pkg::STAT_FULL;
                else model_insert(r.value);
            end
            sapq_pkg::FUNC_DEQUEUE: begin
                if (model_fill == 0) begin
                    rsp.status = sapq_pkg::STAT_EMPTY;
                end else begin
                    rsp.data_out = model_ent[0];
                    model_remove(0);
                end
            end
            sapq_pkg::FUNC_SEARCH: begin
                if (model_fill == 0) begin
                    rsp.status = sapq_pkg::STAT_EMPTY;
                end else begin
                    idx = model_find(r.value);
                    if (idx == model_fill) rsp.status = sapq_pkg::STAT_NOTFOUND;
                    else rsp.position = 5'(idx + 1);
                end
            end
            sapq_pkg::FUNC_UPDATE: begin
                if (model_fill == 0) begin
                    rsp.status = sapq_pkg::STAT_EMPTY;
                end else begin
                    idx = model_find(r.value);
                    if (idx == model_fill) begin
                        rsp.status = sapq_pkg::STAT_NOTFOUND;
                    end else begin
                        model_remove(idx);
                        model_insert(r.new_value);
                    end
                end
            end
            sapq_pkg::FUNC_CLEAR: model_fill = 0;
            default: ;
        endcase
        rsp.count      = 5'(model_fill);
        rsp.is_empty   = (model_fill == 0);
        rsp.head_value = (model_fill == 0) ? 32'sd0 : model_ent[0];
        return rsp;
    endfunction

    function automatic void add_request(input logic [2:0] func, input logic signed [31:0] v,
                                        input logic signed [31:0] nv, input bit drain);
        t_pq_request item;
        item.req.func      = func;
        item.req.value     = v;
        item.req.new_value = nv;
        item.drain_before  = drain;
        pending_reqs.push_back(item);
    endfunction

    // values seen before most often, small values for duplicates, some wide and extreme ones
    function automatic logic signed [31:0] pick_value();
        int                 sel;
        logic signed [31:0] v;
        sel = $urandom_range(0, 99);
        if (sel < 40 && value_pool.size() != 0) begin
            v = value_pool[$urandom_range(0, value_pool.size() - 1)];
        end else if (sel < 70) begin
            v = int'($urandom_range(0, 16)) - 8;
        end else if (sel < 90) begin
            v = $urandom;
        end else begin
            case ($urandom_range(0, 3))
                0:       v = VAL_MIN;
                1:       v = VAL_MAX;
                2:       v = -32'sd1;
                default: v = 32'sd0;
            endcase
        end
        return v;
    endfunction

    function automatic void remember_value(input logic signed [31:0] v);
        value_pool.push_back(v);
        if (value_pool.size() > POOL_DEPTH) void'(value_pool.pop_front());
    endfunction

    // request driver: bursts of beats with random gaps, optional drain before a beat
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start      <= 1'b0;
            n_sent     <= 0;
            burst_left = 0;
            gap_left   = 0;
        end else begin
            took = start && !busy;
            if (took) begin
                expected_rsps.push_back(apply_queue_op(i_req));
                n_sent <= n_sent + 1;
            end
            if (start && !took) begin
                // beat still waiting on busy, hold it
            end else if (gap_left > 0) begin
                start <= 1'b0;
                gap_left--;
            end else if (pending_reqs.size() != 0 &&
                         (!pending_reqs[0].drain_before || (!took && n_sent == n_checked))) begin
                i_req <= pending_reqs[0].req;
                start <= 1'b1;
                void'(pending_reqs.pop_front());
                if (burst_left <= 1) begin
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 10);
                end else begin
                    burst_left--;
                end
            end else begin
                start <= 1'b0;
            end
        end
    end

    // result monitor: every strobed beat against the oldest prediction
    always @(posedge i_clk) begin
        sapq_pkg::t_rsp want;
        if (!i_rst_n) begin
            n_checked <= 0;
        end else if (o_strobe) begin
            if (expected_rsps.size() == 0) begin
                $error("result beat with nothing expected: %p", o_rsp);
                n_errors++;
            end else begin
                want = expected_rsps.pop_front();
                n_checked <= n_checked + 1;
                if (o_rsp.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_rsp.status);
                    n_errors++;
                end
                if (o_rsp.data_out !== want.data_out) begin
                    $error("data_out: expected %0d, got %0d", want.data_out, o_rsp.data_out);
                    n_errors++;
                end
                if (o_rsp.position !== want.position) begin
                    $error("position: expected %0d, got %0d", want.position, o_rsp.position);
                    n_errors++;
                end
                if (o_rsp.count !== want.count) begin
                    $error("count: expected %0d, got %0d", want.count, o_rsp.count);
                    n_errors++;
                end
                if (o_rsp.is_empty !== want.is_empty) begin
                    $error("is_empty: expected %0d, got %0d", want.is_empty, o_rsp.is_empty);
                    n_errors++;
                end
                if (o_rsp.head_value !== want.head_value) begin
                    $error("head_value: expected %0d, got %0d", want.head_value,
                           o_rsp.head_value);
                    n_errors++;
                end
            end
        end
    end

    // watchdog on cycles with no beat moving either way
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // stimulus, reset and end of run
    initial begin
        int                 sel;
        int                 enq_pct;
        int                 deq_pct;
        logic [2:0]         func;
        logic signed [31:0] v;
        logic signed [31:0] nv;

        // empty queue, extremes, duplicates, hits and misses, spare codes, clear
        add_request(sapq_pkg::FUNC_DEQUEUE, 32'sd0, 32'sd0, 1'b0);
        add_request(sapq_pkg::FUNC_SEARCH, 32'sd0, 32'sd0, 1'b0);
        add_request(sapq_pkg::FUNC_UPDATE, 32'sd0, 32'sd1, 1'b0);
        add_request(sapq_pkg::FUNC_ENQUEUE, VAL_MAX, 32'sd0, 1'b0);
        add_request(sapq_pkg::FUNC_ENQUEUE, VAL_MIN, 32'sd0, 1'b0);
        add_request(sapq_pkg::FUNC_ENQUEUE, 32'sd0, 32'sd0, 1'b0);
        add_request(sapq_pkg::FUNC_ENQUEUE, 32'sd0, 32'sd0, 1'b0);
        add_request(sapq_pkg::FUNC_ENQUEUE, -32'sd1, -32'sd1, 1'b0);
        add_request(sapq_pkg::FUNC_SEARCH, 32'sd0, 32'sd0, 1'b0);
        add_request(sapq_pkg::FUNC_SEARCH, 32'sd7, 32'sd0, 1'b0);
        add_request(sapq_pkg::FUNC_SEARCH, VAL_MAX, 32'sd0, 1'b0);
        add_request(sapq_pkg::FUNC_UPDATE, 32'sd99, 32'sd1, 1'b0);
        add_request(sapq_pkg::FUNC_UPDATE, VAL_MAX, VAL_MIN, 1'b0);
        add_request(sapq_pkg::FUNC_UPDATE, 32'sd0, VAL_MAX, 1'b0);
        add_request(FUNC_SPARE_LO, -32'sd1, -32'sd1, 1'b0);
        add_request(FUNC_SPARE_MID, VAL_MAX, VAL_MIN, 1'b0);
        add_request(FUNC_SPARE_HI, VAL_MIN, VAL_MAX, 1'b0);
        add_request(sapq_pkg::FUNC_DEQUEUE, 32'sd0, 32'sd0, 1'b0);
        add_request(sapq_pkg::FUNC_DEQUEUE, 32'sd0, 32'sd0, 1'b0);
        add_request(sapq_pkg::FUNC_CLEAR, -32'sd1, -32'sd1, 1'b0);
        add_request(sapq_pkg::FUNC_CLEAR, 32'sd0, 32'sd0, 1'b0);
        add_request(sapq_pkg::FUNC_DEQUEUE, 32'sd0, 32'sd0, 1'b0);

        // random phases: filling, draining and mixed, each opening on a drained block
        for (int p = 0; p < PHASE_COUNT; p++) begin
            case (p % 3)
                0: begin
                    enq_pct = 75;
                    deq_pct = 8;
                end
                1: begin
                    enq_pct = 15;
                    deq_pct = 55;
                end
                default: begin
                    enq_pct = 35;
                    deq_pct = 25;
                end
            endcase
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                sel = $urandom_range(0, 99);
                v   = pick_value();
                nv  = $urandom;
                if (sel < enq_pct) begin
                    func = sapq_pkg::FUNC_ENQUEUE;
                    remember_value(v);
                end else if (sel < enq_pct + deq_pct) begin
                    func = sapq_pkg::FUNC_DEQUEUE;
                end else if (sel < 98) begin
                    if ($urandom_range(0, 1) == 0) begin
                        func = sapq_pkg::FUNC_SEARCH;
                    end else begin
                        func = sapq_pkg::FUNC_UPDATE;
                        nv   = pick_value();
                        remember_value(nv);
                    end
                end else if (sel == 98) begin
                    func = sapq_pkg::FUNC_CLEAR;
                end else begin
                    func = 3'(FUNC_SPARE_LO + $urandom_range(0, 2));
                end
                add_request(func, v, nv, k == 0);
            end
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // wait for the last request beat and its result
        @(posedge i_clk);
        while (pending_reqs.size() != 0 || start || n_checked != n_sent) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        if (expected_rsps.size() != 0) begin
            $error("%0d result beats never arrived", expected_rsps.size());
            n_errors++;
        end
        if (n_errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

`default_nettype wire

>>> sim.f
design/sapq_pkg.sv
design/sapq_cell.sv
design/sorted_array_priority_queue_core.sv
design/sapq_checker.sv
sim/tb.sv
